// ----- rtl/bblur_pkg.sv -----
// Shared types, constants and the reciprocal table of the 3x3 box blur.
// No dependencies; the front, queue and back modules and the top unit import this package.
`default_nettype none

package bblur_pkg;

    // item codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam int FW_W = 11;
    localparam int FH_W = 16;

    // arithmetic widths
    localparam int CHAN_W      = 8;
    localparam int CNT_W       = 4;
    localparam int SUM_W       = 12;
    localparam int NUM_W       = 13;
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_W     = 18;
    localparam int PROD_W      = NUM_W + RECIP_W;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    // one window column: index 0 top, 1 middle, 2 bottom
    typedef t_rgb [2:0] t_col;

    // per-item control decided by the front
    typedef struct packed {
        logic emit;
        logic use_left;
        logic use_right;
        logic use_top;
        logic use_bottom;
        logic frame_end;
    } t_ctrl;

    typedef struct packed {
        t_col  col;
        t_ctrl ctrl;
    } t_qentry;

    // ceil(2^18 / (2*count)); exact floor division for numerators below 2^13
    function automatic logic [RECIP_W-1:0] f_recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        begin
            unique case (cnt)
                4'd1:    m = 18'd131072;
                4'd2:    m = 18'd65536;
                4'd3:    m = 18'd43691;
                4'd4:    m = 18'd32768;
                4'd6:    m = 18'd21846;
                4'd9:    m = 18'd14564;
                default: m = '0;
            endcase
            return m;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bblur_in_if.sv -----
// Input channel of the box blur: valid/ready with one pixel or drain item per beat.
// No dependencies.
`default_nettype none

interface bblur_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;

    modport source (output valid, output cmd, output in_red, output in_green,
                    output in_blue, input ready);
    modport sink   (input valid, input cmd, input in_red, input in_green,
                    input in_blue, output ready);
endinterface

`default_nettype wire

// ----- rtl/bblur_out_if.sv -----
// Output channel of the box blur: valid/ready with one filtered pixel per beat.
// No dependencies.
`default_nettype none

interface bblur_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output frame_end, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input frame_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/bblur_front.sv -----
// Front of the box blur: config registers, position counters, line stores.
// Depends on bblur_pkg and bblur_in_if; feeds one column per item to the queue.
`default_nettype none

module bblur_front
    import bblur_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data,
    bblur_in_if.sink              i_pix,
    input  wire                   i_q_ready,
    output logic                  o_push,
    output t_qentry               o_entry
);

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int MW_W   = $clog2(MAX_WIDTH + 1);
    localparam int WCMP_W = (MW_W > FW_W) ? MW_W : FW_W;
    localparam int RST_W  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam logic [WCMP_W-1:0] MAXW = WCMP_W'(MAX_WIDTH);

    // input row code: only zero, one and two-or-more matter
    localparam logic [1:0] ROW_0     = 2'd0;
    localparam logic [1:0] ROW_1     = 2'd1;
    localparam logic [1:0] ROW_2PLUS = 2'd2;

    logic [COL_W-1:0]  r_wlast;
    logic [FH_W-1:0]   r_hlast;
    logic [COL_W-1:0]  r_in_col,  n_in_col;
    logic [1:0]        r_in_row,  n_in_row;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic [FH_W-1:0]   r_out_row, n_out_row;

    logic [23:0]       r_older_mem [MAX_WIDTH];
    logic [23:0]       r_newer_mem [MAX_WIDTH];
    logic [23:0]       r_older_rd;
    logic [23:0]       r_newer_rd;

    logic              r_b_valid;
    logic [COL_W-1:0]  r_b_col;
    t_rgb              r_b_pix;
    t_ctrl             r_b_ctrl;
    logic              r_b_hit;
    t_rgb              r_b_fwd_older;
    t_rgb              r_b_fwd_newer;

    logic              a_fire;
    logic              b_fire;
    logic              cfg_restart;
    logic              a_emit;
    t_ctrl             a_ctrl;
    t_rgb              a_pix;
    t_rgb              b_older;
    t_rgb              b_newer;
    logic [WCMP_W-1:0] fw_ext;
    logic [COL_W-1:0]  new_wlast;
    logic [FH_W-1:0]   new_hlast;

    // handshake between stage a (accept, read) and stage b (write, push)
    assign b_fire      = r_b_valid && i_q_ready;
    assign i_pix.ready = !r_b_valid || i_q_ready;
    assign a_fire      = i_pix.valid && i_pix.ready;
    assign cfg_restart = i_cfg_we &&
                         ((i_cfg_idx == CFG_FRAME_WIDTH) || (i_cfg_idx == CFG_FRAME_HEIGHT));

    // saturated register values kept as last index
    always_comb begin
        fw_ext = WCMP_W'(i_cfg_data[FW_W-1:0]);
        if (fw_ext == '0) begin
            new_wlast = '0;
        end else if (fw_ext > MAXW) begin
            new_wlast = COL_W'(MAXW - WCMP_W'(1));
        end else begin
            new_wlast = COL_W'(fw_ext - WCMP_W'(1));
        end
        if (i_cfg_data[FH_W-1:0] == '0) begin
            new_hlast = '0;
        end else begin
            new_hlast = i_cfg_data[FH_W-1:0] - FH_W'(1);
        end
    end

    // item classification and counter advance
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        a_ctrl    = '0;
        a_pix     = (i_pix.cmd == CMD_PIXEL) ?
                    t_rgb'{i_pix.in_red, i_pix.in_green, i_pix.in_blue} : '0;
        a_emit    = (r_in_row == ROW_2PLUS) || ((r_in_row == ROW_1) && (r_in_col != '0));

        if (r_in_col == r_wlast) begin
            n_in_col = '0;
            if (r_in_row != ROW_2PLUS) begin
                n_in_row = r_in_row + 2'd1;
            end
        end else begin
            n_in_col = r_in_col + COL_W'(1);
        end

        if (a_emit) begin
            a_ctrl.emit       = 1'b1;
            a_ctrl.use_left   = (r_out_col != '0);
            a_ctrl.use_right  = (r_out_col != r_wlast);
            a_ctrl.use_top    = (r_out_row != '0);
            a_ctrl.use_bottom = (r_out_row != r_hlast);
            a_ctrl.frame_end  = (r_out_col == r_wlast) && (r_out_row == r_hlast);
            if (a_ctrl.frame_end) begin
                n_in_col  = '0;
                n_in_row  = ROW_0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (r_out_col == r_wlast) begin
                n_out_col = '0;
                n_out_row = r_out_row + FH_W'(1);
            end else begin
                n_out_col = r_out_col + COL_W'(1);
            end
        end
    end

    // config and position registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast   <= COL_W'(RST_W - 1);
            r_hlast   <= '0;
            r_in_col  <= '0;
            r_in_row  <= ROW_0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (cfg_restart) begin
            if (i_cfg_idx == CFG_FRAME_WIDTH) begin
                r_wlast <= new_wlast;
            end else begin
                r_hlast <= new_hlast;
            end
            r_in_col  <= '0;
            r_in_row  <= ROW_0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (a_fire) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // stage b valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_fire) begin
            r_b_valid <= 1'b1;
        end else if (b_fire) begin
            r_b_valid <= 1'b0;
        end
    end

    // stage b payload, with bypass when the item ahead writes the same column
    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_b_col       <= r_in_col;
            r_b_pix       <= a_pix;
            r_b_ctrl      <= a_ctrl;
            r_b_hit       <= b_fire && (r_b_col == r_in_col);
            r_b_fwd_older <= b_newer;
            r_b_fwd_newer <= r_b_pix;
        end
    end

    // line stores: read at accept, rotate at push
    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_older_rd <= r_older_mem[r_in_col];
            r_newer_rd <= r_newer_mem[r_in_col];
        end
        if (b_fire) begin
            r_older_mem[r_b_col] <= b_newer;
            r_newer_mem[r_b_col] <= r_b_pix;
        end
    end

    assign b_older = r_b_hit ? r_b_fwd_older : t_rgb'(r_older_rd);
    assign b_newer = r_b_hit ? r_b_fwd_newer : t_rgb'(r_newer_rd);

    // column pushed to the back
    assign o_push        = b_fire;
    assign o_entry.col   = {r_b_pix, b_newer, b_older};
    assign o_entry.ctrl  = r_b_ctrl;

    a_in_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_col <= r_wlast)
        else $error("input column beyond row width");

    a_out_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_col <= r_wlast)
        else $error("output column beyond row width");

endmodule

`default_nettype wire

// ----- rtl/bblur_queue.sv -----
// Short queue of columns between the front and the back of the box blur.
// Depends on bblur_pkg.
`default_nettype none

module bblur_queue
    import bblur_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_push,
    input  wire t_qentry i_entry,
    output logic         o_ready,
    input  wire          i_pop,
    output logic         o_valid,
    output t_qentry      o_entry
);

    t_qentry           r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_ready = (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_slot[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- rtl/bblur_back.sv -----
// Back of the box blur: 3x3 window, masked channel sums, rounded mean, output register.
// Depends on bblur_pkg and bblur_out_if; takes columns from the queue.
`default_nettype none

module bblur_back
    import bblur_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_q_valid,
    input  wire t_qentry i_entry,
    output logic         o_pop,
    bblur_out_if.source  o_pix
);

    t_col               r_win [3];
    logic               r_s1_valid;
    t_ctrl              r_s1_ctrl;
    logic               r_s2_valid;
    logic               r_s2_fe;
    logic [NUM_W-1:0]   r_s2_num_r, r_s2_num_g, r_s2_num_b;
    logic [RECIP_W-1:0] r_s2_recip;
    logic               r_s3_valid;
    logic               r_s3_fe;
    logic [PROD_W-1:0]  r_s3_prod_r, r_s3_prod_g, r_s3_prod_b;
    logic               r_out_valid;
    logic               r_out_fe;
    logic [CHAN_W-1:0]  r_out_r, r_out_g, r_out_b;

    logic               en;
    logic [2:0]         col_ok;
    logic [2:0]         row_ok;
    logic [SUM_W-1:0]   sum_r, sum_g, sum_b;
    logic [CNT_W-1:0]   cnt;

    // whole back advances unless a result waits at the output and is not taken
    assign en    = !r_out_valid || o_pix.ready;
    assign o_pop = en && i_q_valid;

    // window shift on every item, emitting or not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win[0] <= '0;
            r_win[1] <= '0;
            r_win[2] <= '0;
        end else if (o_pop) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= i_entry.col;
        end
    end

    // masked sums over the window and neighbor count
    always_comb begin
        col_ok = {r_s1_ctrl.use_right, 1'b1, r_s1_ctrl.use_left};
        row_ok = {r_s1_ctrl.use_bottom, 1'b1, r_s1_ctrl.use_top};
        sum_r  = '0;
        sum_g  = '0;
        sum_b  = '0;
        cnt    = '0;
        for (int s = 0; s < 3; s++) begin
            for (int k = 0; k < 3; k++) begin
                if (col_ok[s] && row_ok[k]) begin
                    sum_r = sum_r + SUM_W'(r_win[s][k].red);
                    sum_g = sum_g + SUM_W'(r_win[s][k].green);
                    sum_b = sum_b + SUM_W'(r_win[s][k].blue);
                    cnt   = cnt + CNT_W'(1);
                end
            end
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= o_pop && i_entry.ctrl.emit;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    // numerator 2*sum+count, reciprocal of 2*count, product, quotient
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ctrl   <= i_entry.ctrl;
            r_s2_fe     <= r_s1_ctrl.frame_end;
            r_s2_num_r  <= NUM_W'({sum_r, 1'b0}) + NUM_W'(cnt);
            r_s2_num_g  <= NUM_W'({sum_g, 1'b0}) + NUM_W'(cnt);
            r_s2_num_b  <= NUM_W'({sum_b, 1'b0}) + NUM_W'(cnt);
            r_s2_recip  <= f_recip(cnt);
            r_s3_fe     <= r_s2_fe;
            r_s3_prod_r <= PROD_W'(r_s2_num_r) * PROD_W'(r_s2_recip);
            r_s3_prod_g <= PROD_W'(r_s2_num_g) * PROD_W'(r_s2_recip);
            r_s3_prod_b <= PROD_W'(r_s2_num_b) * PROD_W'(r_s2_recip);
            r_out_fe    <= r_s3_fe;
            r_out_r     <= r_s3_prod_r[RECIP_SHIFT +: CHAN_W];
            r_out_g     <= r_s3_prod_g[RECIP_SHIFT +: CHAN_W];
            r_out_b     <= r_s3_prod_b[RECIP_SHIFT +: CHAN_W];
        end
    end

    assign o_pix.valid     = r_out_valid;
    assign o_pix.out_red   = r_out_r;
    assign o_pix.out_green = r_out_g;
    assign o_pix.out_blue  = r_out_b;
    assign o_pix.frame_end = r_out_fe;

endmodule

`default_nettype wire

// ----- rtl/box_blur_3x3_edge_aware_unit.sv -----
// 3x3 box blur over RGB, neighbors outside the frame left out; bblur_front, _queue, _back.
// Throughput one item per cycle while the output is taken; the front line stores take one
// read and one write a cycle. The item at position width+1 past a pixel yields its result.
// Reset clears counters, queue and pipeline; width 1024 (capped at MAX_WIDTH), height 1.
// Line stores are not cleared after reset; there is no clearing pass.
`default_nettype none

module box_blur_3x3_edge_aware_unit
    import bblur_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data,
    bblur_in_if.sink              i_pix,
    bblur_out_if.source           o_pix
);

    logic    q_ready;
    logic    q_push;
    t_qentry q_in;
    logic    q_valid;
    logic    q_pop;
    t_qentry q_out;

    // accept, classify, line stores
    bblur_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .i_q_ready  (q_ready),
        .o_push     (q_push),
        .o_entry    (q_in)
    );

    // decoupling queue
    bblur_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_out)
    );

    // window and arithmetic
    bblur_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_entry   (q_out),
        .o_pop     (q_pop),
        .o_pix     (o_pix)
    );

endmodule

`default_nettype wire
